### rtl/cbm_pkg.sv
// shared types and decode constants for the cartridge bank and cycle irq mapper
// no dependencies; imported by the core and the top level
package cbm_pkg;

  // bus write addresses, matched exactly
  localparam logic [15:0] ADDR_NIB0   = 16'h8000;
  localparam logic [15:0] ADDR_NIB1   = 16'h9000;
  localparam logic [15:0] ADDR_NIB2   = 16'hA000;
  localparam logic [15:0] ADDR_NIB3   = 16'hB000;
  localparam logic [15:0] ADDR_ARM    = 16'hC000;
  localparam logic [15:0] ADDR_SELECT = 16'hE000;
  localparam logic [15:0] ADDR_LOAD   = 16'hF000;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // counter fires when the lossless sum reaches this value
  localparam logic [16:0] IRQ_LIMIT = 17'h0FFFF;

  localparam int BANK_COUNT = 8;
  localparam int SEL_W      = $clog2(BANK_COUNT);

  // bank register indexes for the reported windows
  localparam logic [SEL_W-1:0] REG_6000 = 3'd4;
  localparam logic [SEL_W-1:0] REG_8000 = 3'd1;
  localparam logic [SEL_W-1:0] REG_A000 = 3'd2;
  localparam logic [SEL_W-1:0] REG_C000 = 3'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } cmd_t;

  typedef struct packed {
    logic       irq_line;
    logic [7:0] bank_6000;
    logic [7:0] bank_8000;
    logic [7:0] bank_a000;
    logic [7:0] bank_c000;
  } res_t;

endpackage

### rtl/cbm_if.sv
// valid/ready channel interfaces for the mapper command and result beats
// no dependencies beyond plain logic signals
interface cbm_cmd_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  cycles;

  modport source (output valid, output action, output address, output data,
                  output cycles, input ready);
  modport sink   (input valid, input action, input address, input data,
                  input cycles, output ready);
endinterface

interface cbm_res_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [7:0] bank_6000;
  logic [7:0] bank_8000;
  logic [7:0] bank_a000;
  logic [7:0] bank_c000;

  modport source (output valid, output irq_line, output bank_6000, output bank_8000,
                  output bank_a000, output bank_c000, input ready);
  modport sink   (input valid, input irq_line, input bank_6000, input bank_8000,
                  input bank_a000, input bank_c000, output ready);
endinterface

### rtl/cbm_core.sv
// mapper state: bank registers, select, cycle counter and irq flags
// depends on cbm_pkg; updates state once per step and reports post-update values
module cbm_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  cbm_pkg::cmd_t cmd,
  output cbm_pkg::res_t res
);
  import cbm_pkg::*;

  logic [7:0]       bank [BANK_COUNT];
  logic [7:0]       bank_next [BANK_COUNT];
  logic [SEL_W-1:0] sel, sel_next;
  logic             armed, armed_next;
  logic [15:0]      counter, counter_next;
  logic             asserted, asserted_next;
  logic [16:0]      sum;
  logic             fire;

  // lossless counter sum for a tick
  assign sum  = {1'b0, counter} + {9'b0, cmd.cycles};
  assign fire = step && (cmd.action == ACT_TICK) && armed && (sum >= IRQ_LIMIT);

  // next state for one beat
  always_comb begin
    bank_next     = bank;
    sel_next      = sel;
    armed_next    = armed;
    counter_next  = counter;
    asserted_next = asserted;
    if (step) begin
      if (cmd.action == ACT_TICK) begin
        if (armed) begin
          if (fire) begin
            counter_next  = '0;
            armed_next    = 1'b0;
            asserted_next = 1'b1;
          end else begin
            counter_next = sum[15:0];
          end
        end
      end else begin
        unique case (cmd.address)
          ADDR_NIB0: begin
            counter_next[3:0] = cmd.data[3:0];
            asserted_next     = 1'b0;
          end
          ADDR_NIB1: begin
            counter_next[7:4] = cmd.data[3:0];
            asserted_next     = 1'b0;
          end
          ADDR_NIB2: begin
            counter_next[11:8] = cmd.data[3:0];
            asserted_next      = 1'b0;
          end
          ADDR_NIB3: begin
            counter_next[15:12] = cmd.data[3:0];
            asserted_next       = 1'b0;
          end
          ADDR_ARM: begin
            asserted_next = 1'b0;
            armed_next    = 1'b1;
          end
          ADDR_SELECT: sel_next = cmd.data[SEL_W-1:0];
          ADDR_LOAD:   bank_next[sel] = cmd.data;
          default: ;
        endcase
      end
    end
  end

  // result is taken after the update
  assign res.irq_line  = asserted_next;
  assign res.bank_6000 = bank_next[REG_6000];
  assign res.bank_8000 = bank_next[REG_8000];
  assign res.bank_a000 = bank_next[REG_A000];
  assign res.bank_c000 = bank_next[REG_C000];

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANK_COUNT; i++) begin
        bank[i] <= '0;
      end
      sel      <= '0;
      armed    <= 1'b0;
      counter  <= '0;
      asserted <= 1'b0;
    end else begin
      bank     <= bank_next;
      sel      <= sel_next;
      armed    <= armed_next;
      counter  <= counter_next;
      asserted <= asserted_next;
    end
  end

`ifndef ASSERT_OFF
  // firing disarms, and arming clears the irq, so both are never set
  a_irq_not_armed: assert property (@(posedge clk) disable iff (rst)
    asserted |-> !armed)
    else $error("irq asserted while counter armed");

  // a fire leaves the counter cleared
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    fire |=> (counter == '0) && asserted)
    else $error("counter not cleared after fire");

  // a tick while disarmed changes nothing in the counter path
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (step && (cmd.action == ACT_TICK) && !armed) |=>
      ($stable(counter) && $stable(asserted) && !armed))
    else $error("disarmed tick changed counter state");
`endif

endmodule

### rtl/cartridge_bank_and_cycle_irq_mapper_unit.sv
// Counter add-compare and bank decode lie between the input register and the result register.
// Throughput: one beat per cycle while the result is not stalled.
// An input register and a result register part the two sides, so one more beat is
// taken while a result is stalled.
// Reset: synchronous rst clears bank registers, select, counter and irq flags at once.
// Top level: command/result channels around the mapper core; depends on cbm_pkg, cbm_if
// and cbm_core
module cartridge_bank_and_cycle_irq_mapper_unit (
  input  logic clk,
  input  logic rst,
  cbm_cmd_if.sink   cmd,
  cbm_res_if.source res
);
  import cbm_pkg::*;

  logic in_full;
  cmd_t in_item;
  logic out_full;
  res_t out_item;
  res_t core_res;
  logic advance;

  // move the held beat into the result register when it is free or being taken
  assign advance   = in_full && (!out_full || res.ready);
  assign cmd.ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd.ready) begin
      in_full <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      in_item.action  <= cmd.action;
      in_item.address <= cmd.address;
      in_item.data    <= cmd.data;
      in_item.cycles  <= cmd.cycles;
    end
  end

  cbm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (in_item),
    .res  (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (res.ready) begin
      out_full <= 1'b0;
    end
    if (advance) begin
      out_item <= core_res;
    end
  end

  assign res.valid     = out_full;
  assign res.irq_line  = out_item.irq_line;
  assign res.bank_6000 = out_item.bank_6000;
  assign res.bank_8000 = out_item.bank_8000;
  assign res.bank_a000 = out_item.bank_a000;
  assign res.bank_c000 = out_item.bank_c000;

`ifndef ASSERT_OFF
  // a held command that cannot advance stays held unchanged
  a_hold_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_item)))
    else $error("held command lost while stalled");

  // a new result appears only from an advancing command
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    (!out_full || res.ready) && !advance |=> !out_full)
    else $error("result beat without a command");

  // a stalled result never gets overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_full && !res.ready) |=> (out_full && $stable(out_item)))
    else $error("stalled result overwritten");
`endif

endmodule
